// ===== src/pcpfa_pkg.sv =====
// Shared constants, types and codes of the per-CPU page free-list allocator.
`timescale 1ns / 1ps
`default_nettype none
package pcpfa_pkg;

	localparam int NUM_CPUS    = 8;
	localparam int STEAL_BATCH = 8;
	localparam int MAX_PAGES   = 32768;
	localparam int PAGE_BYTES  = 4096;

	localparam int ADDR_W    = 40;
	localparam int CPU_W     = 3;
	localparam int NCPU_W    = 4;
	localparam int OFF_W     = $clog2(PAGE_BYTES);
	localparam int FRAME_W   = ADDR_W - OFF_W;
	localparam int PG_W      = $clog2(MAX_PAGES);
	localparam int CNT_W     = $clog2(STEAL_BATCH + 1);
	localparam int REG_IDX_W = 2;
	localparam int PADDR_W   = REG_IDX_W + 3;
	localparam int PDATA_W   = 64;

	localparam logic [NCPU_W-1:0] NUM_CPUS_MAX  = NCPU_W'(NUM_CPUS);
	localparam logic [CNT_W-1:0]  STEAL_MAX     = CNT_W'(STEAL_BATCH);
	localparam logic [NCPU_W-1:0] NUM_CPUS_RST  = 4'd1;
	localparam logic [ADDR_W-1:0] REG_START_RST = 40'h00_8000_0000;
	localparam logic [ADDR_W-1:0] REG_END_RST   = 40'h00_8800_0000;

	typedef logic [PG_W-1:0] page_t;

	typedef struct packed {
		logic  valid;
		page_t next;
	} link_t;

	typedef struct packed {
		logic [NCPU_W-1:0] num_cpus;
		logic [ADDR_W-1:0] region_start;
		logic [ADDR_W-1:0] region_end;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OOM      = 2'd1,
		ST_BAD_ADDR = 2'd2,
		ST_BAD_CPU  = 2'd3
	} status_t;

	typedef enum logic {
		CMD_FREE  = 1'b0,
		CMD_ALLOC = 1'b1
	} cmd_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_NUM_CPUS     = 2'd0,
		REG_REGION_START = 2'd1,
		REG_REGION_END   = 2'd2
	} reg_idx_t;

endpackage
`default_nettype wire

// ===== src/pcpfa_regs.sv =====
// APB configuration registers of the page allocator.
`timescale 1ns / 1ps
`default_nettype none
module pcpfa_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pcpfa_pkg::PADDR_W-1:0] paddr,
	input  wire logic [pcpfa_pkg::PDATA_W-1:0] pwdata,
	output logic      [pcpfa_pkg::PDATA_W-1:0] prdata,
	output logic                               pready,
	output pcpfa_pkg::cfg_t                    cfg
);
	import pcpfa_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_cpus     <= NUM_CPUS_RST;
			cfg_q.region_start <= REG_START_RST;
			cfg_q.region_end   <= REG_END_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_NUM_CPUS:     cfg_q.num_cpus     <= pwdata[NCPU_W-1:0];
				REG_REGION_START: cfg_q.region_start <= pwdata[ADDR_W-1:0];
				REG_REGION_END:   cfg_q.region_end   <= pwdata[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_NUM_CPUS:     prdata = PDATA_W'(cfg_q.num_cpus);
			REG_REGION_START: prdata = PDATA_W'(cfg_q.region_start);
			REG_REGION_END:   prdata = PDATA_W'(cfg_q.region_end);
			default:          prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== src/pcpfa_alu.sv =====
// Shared registered add/subtract unit used for bounds checks and address arithmetic.
`timescale 1ns / 1ps
`default_nettype none
module pcpfa_alu (
	input  wire logic                         clk,
	input  wire pcpfa_pkg::alu_op_t           op,
	input  wire logic [pcpfa_pkg::ADDR_W-1:0] a,
	input  wire logic [pcpfa_pkg::ADDR_W-1:0] b,
	output logic      [pcpfa_pkg::ADDR_W-1:0] res_q,
	output logic                              borrow_q
);
	import pcpfa_pkg::*;

	logic [ADDR_W:0] sum;

	always_comb begin
		case (op)
			ALU_SUB: sum = {1'b0, a} - {1'b0, b};
			default: sum = {1'b0, a} + {1'b0, b};
		endcase
	end

	always_ff @(posedge clk) begin
		res_q    <= sum[ADDR_W-1:0];
		borrow_q <= sum[ADDR_W];
	end

endmodule
`default_nettype wire

// ===== src/per_cpu_page_free_list_allocator.sv =====
// Top level of the per-CPU page free-list allocator with list stealing.
// Free: the cpu and the page alignment are checked first, then the lower and the upper region
// bound, then the page number, and the page is pushed onto the caller's list. Allocation pops
// the caller's own list; if it is empty, the other lists are scanned downward and the first
// with pages gives up to 8 of them to the caller; out of memory when the scan returns to the caller.
// One command at a time: busy stays high until the result beat, which cannot be stalled.
// Reset empties all lists and restores the registers at once; the link memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module per_cpu_page_free_list_allocator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          command,
	input  wire logic [pcpfa_pkg::CPU_W-1:0]   cpu_id,
	input  wire logic [pcpfa_pkg::ADDR_W-1:0]  page_address,
	output logic                               done,
	output logic      [pcpfa_pkg::ADDR_W-1:0]  granted_address,
	output pcpfa_pkg::status_t                 status,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pcpfa_pkg::PADDR_W-1:0] paddr,
	input  wire logic [pcpfa_pkg::PDATA_W-1:0] pwdata,
	output logic      [pcpfa_pkg::PDATA_W-1:0] prdata,
	output logic                               pready
);
	import pcpfa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_LO,
		S_HI,
		S_PN,
		S_PUSH,
		S_SCAN,
		S_SRD,
		S_SWALK,
		S_SEND,
		S_PRD,
		S_PPOP,
		S_ADDR,
		S_DONE
	} state_t;

	cfg_t    cfg;
	state_t  state_q;
	logic    cmd_q;
	logic [CPU_W-1:0]  id_q;
	logic [CPU_W-1:0]  i_q;
	logic [ADDR_W-1:0] addr_q;
	page_t   first_q;
	page_t   last_q;
	page_t   pg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic    done_q;
	status_t status_q;
	logic [ADDR_W-1:0] gaddr_q;

	page_t   head_q   [NUM_CPUS];
	logic [NUM_CPUS-1:0] hvalid_q;

	link_t   mem_q    [MAX_PAGES];
	link_t   rdata_q;
	logic    mem_we;
	page_t   mem_waddr;
	link_t   mem_wdata;

	alu_op_t alu_op;
	logic [ADDR_W-1:0] alu_a;
	logic [ADDR_W-1:0] alu_b;
	logic [ADDR_W-1:0] alu_res;
	logic    alu_borrow;

	logic [NCPU_W-1:0] ncpu;
	logic [CPU_W-1:0]  hsel;
	page_t   head_rd;
	logic    id_bad;
	logic    pn_ok;
	logic [CPU_W-1:0]  prev_id;
	logic [CPU_W-1:0]  prev_i;
	logic [ADDR_W-1:0] start_frame;

	pcpfa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pcpfa_alu u_alu (
		.clk      (clk),
		.op       (alu_op),
		.a        (alu_a),
		.b        (alu_b),
		.res_q    (alu_res),
		.borrow_q (alu_borrow)
	);

	always_comb begin
		if (cfg.num_cpus == '0) begin
			ncpu = NCPU_W'(1);
		end else if (cfg.num_cpus > NUM_CPUS_MAX) begin
			ncpu = NUM_CPUS_MAX;
		end else begin
			ncpu = cfg.num_cpus;
		end
	end

	assign id_bad      = NCPU_W'(id_q) >= ncpu;
	assign prev_id     = (id_q == '0) ? CPU_W'(ncpu - NCPU_W'(1)) : id_q - CPU_W'(1);
	assign prev_i      = (i_q == '0) ? CPU_W'(ncpu - NCPU_W'(1)) : i_q - CPU_W'(1);
	assign hsel        = (state_q == S_SCAN || state_q == S_SRD || state_q == S_SWALK) ?
		i_q : id_q;
	assign head_rd     = head_q[hsel];
	assign pn_ok       = (alu_res[ADDR_W-1:PG_W] == '0);
	assign start_frame = {{OFF_W{1'b0}}, cfg.region_start[ADDR_W-1:OFF_W]};

	always_comb begin
		alu_op = ALU_SUB;
		alu_a  = addr_q;
		alu_b  = cfg.region_start;
		case (state_q)
			S_HI: begin
				alu_b = cfg.region_end;
			end
			S_PN: begin
				alu_a = {{OFF_W{1'b0}}, addr_q[ADDR_W-1:OFF_W]};
				alu_b = start_frame;
			end
			S_ADDR: begin
				alu_op = ALU_ADD;
				alu_a  = start_frame;
				alu_b  = {{(ADDR_W-PG_W){1'b0}}, pg_q};
			end
			default: ;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = last_q;
		mem_wdata = '0;
		case (state_q)
			S_PUSH: begin
				mem_we    = pn_ok;
				mem_waddr = alu_res[PG_W-1:0];
				mem_wdata = '{valid: hvalid_q[id_q], next: head_rd};
			end
			S_SEND: begin
				mem_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem_q[head_rd];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cmd_q    <= 1'b0;
			id_q     <= '0;
			i_q      <= '0;
			addr_q   <= '0;
			first_q  <= '0;
			last_q   <= '0;
			pg_q     <= '0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			gaddr_q  <= '0;
			hvalid_q <= '0;
			for (int k = 0; k < NUM_CPUS; k++) begin
				head_q[k] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= command;
						id_q    <= cpu_id;
						addr_q  <= page_address;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (id_bad) begin
						done_q   <= 1'b1;
						status_q <= ST_BAD_CPU;
						gaddr_q  <= '0;
						state_q  <= S_IDLE;
					end else if (cmd_q == CMD_ALLOC) begin
						i_q     <= prev_id;
						state_q <= hvalid_q[id_q] ? S_PRD : S_SCAN;
					end else if (addr_q[OFF_W-1:0] != '0) begin
						done_q   <= 1'b1;
						status_q <= ST_BAD_ADDR;
						gaddr_q  <= '0;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_LO;
					end
				end
				S_LO: begin
					state_q <= S_HI;
				end
				S_HI: begin
					if (alu_borrow) begin
						done_q   <= 1'b1;
						status_q <= ST_BAD_ADDR;
						gaddr_q  <= '0;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_PN;
					end
				end
				S_PN: begin
					if (!alu_borrow) begin
						done_q   <= 1'b1;
						status_q <= ST_BAD_ADDR;
						gaddr_q  <= '0;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					done_q  <= 1'b1;
					gaddr_q <= '0;
					state_q <= S_IDLE;
					if (pn_ok) begin
						head_q[id_q]   <= alu_res[PG_W-1:0];
						hvalid_q[id_q] <= 1'b1;
						status_q       <= ST_OK;
					end else begin
						status_q <= ST_BAD_ADDR;
					end
				end
				S_SCAN: begin
					if (i_q == id_q) begin
						done_q   <= 1'b1;
						status_q <= ST_OOM;
						gaddr_q  <= '0;
						state_q  <= S_IDLE;
					end else if (hvalid_q[i_q]) begin
						first_q <= head_rd;
						cnt_q   <= '0;
						state_q <= S_SRD;
					end else begin
						i_q <= prev_i;
					end
				end
				S_SRD: begin
					last_q  <= head_rd;
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_SWALK;
				end
				S_SWALK: begin
					head_q[i_q]   <= rdata_q.next;
					hvalid_q[i_q] <= rdata_q.valid;
					state_q       <= (rdata_q.valid && cnt_q < STEAL_MAX) ? S_SRD : S_SEND;
				end
				S_SEND: begin
					head_q[id_q]   <= first_q;
					hvalid_q[id_q] <= 1'b1;
					state_q        <= S_PRD;
				end
				S_PRD: begin
					pg_q    <= head_rd;
					state_q <= S_PPOP;
				end
				S_PPOP: begin
					head_q[id_q]   <= rdata_q.next;
					hvalid_q[id_q] <= rdata_q.valid;
					state_q        <= S_ADDR;
				end
				S_ADDR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					done_q   <= 1'b1;
					status_q <= ST_OK;
					gaddr_q  <= {alu_res[FRAME_W-1:0], {OFF_W{1'b0}}};
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign status          = status_q;
	assign granted_address = gaddr_q;

endmodule
`default_nettype wire

// ===== src/pcpfa_checker.sv =====
// Port-level checks of the page allocator's command and result beats.
`timescale 1ns / 1ps
`default_nettype none
module pcpfa_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic                         done,
	input wire logic [pcpfa_pkg::ADDR_W-1:0] granted_address,
	input wire pcpfa_pkg::status_t           status
);
	import pcpfa_pkg::*;

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> granted_address == '0)
		else $error("Failed result beat carries a nonzero address.");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("Accepted command did not raise busy.");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Result beat lasted more than one cycle.");

	a_busy_ends_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("Busy dropped without a result beat.");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result beat while still busy.");

endmodule

bind per_cpu_page_free_list_allocator pcpfa_checker u_pcpfa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.granted_address (granted_address),
	.status          (status)
);
`default_nettype wire

// ===== sim/tb_per_cpu_page_free_list_allocator.sv =====
// Self-checking testbench for the per-CPU page free-list allocator: directed cases, then random traffic.
`timescale 1ns / 1ps
module tb_per_cpu_page_free_list_allocator;
	import pcpfa_pkg::*;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		status_t           st;
	} grant_t;

	localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               command = 1'b0;
	logic [CPU_W-1:0]   cpu_id = '0;
	logic [ADDR_W-1:0]  page_address = '0;
	logic               done;
	logic [ADDR_W-1:0]  granted_address;
	status_t            status;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	logic [NCPU_W-1:0] cfg_cpus = NUM_CPUS_RST;
	logic [ADDR_W-1:0] cfg_start = REG_START_RST;
	logic [ADDR_W-1:0] cfg_end = REG_END_RST;

	page_t list_head [NUM_CPUS];
	bit    head_live [NUM_CPUS];
	page_t page_next [MAX_PAGES];
	bit    next_live [MAX_PAGES];

	grant_t            grant_q[$];
	logic [ADDR_W-1:0] held_pages[$];
	int                mismatches = 0;
	int                idle_pct = 0;

	per_cpu_page_free_list_allocator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.cpu_id(cpu_id),
		.page_address(page_address),
		.done(done),
		.granted_address(granted_address),
		.status(status),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	function automatic int eff_cpus();
		if (cfg_cpus == 0)
			return 1;
		if (cfg_cpus > NUM_CPUS)
			return NUM_CPUS;
		return int'(cfg_cpus);
	endfunction

	function automatic int pick_cpu();
		if ($urandom_range(9) == 0)
			return $urandom_range(7);
		return $urandom_range(eff_cpus() - 1);
	endfunction

	// Updates the free lists for one command and returns the grant it yields.
	function automatic grant_t apply_page_op(cmd_t cmd, logic [CPU_W-1:0] cpu,
			logic [ADDR_W-1:0] addr);
		grant_t             g;
		int                 n;
		int                 i;
		int                 cnt;
		logic [FRAME_W-1:0] base;
		logic [FRAME_W-1:0] rel;
		page_t              first;
		page_t              last;
		page_t              pg;
		logic [63:0]        wide;
		n = eff_cpus();
		base = cfg_start[ADDR_W-1:OFF_W];
		g.addr = '0;
		g.st = ST_OK;
		if (int'(cpu) >= n) begin
			g.st = ST_BAD_CPU;
			return g;
		end
		if (cmd == CMD_FREE) begin
			rel = addr[ADDR_W-1:OFF_W] - base;
			if (addr[OFF_W-1:0] != '0 || addr < cfg_start || addr >= cfg_end || rel >= MAX_PAGES) begin
				g.st = ST_BAD_ADDR;
			end else begin
				page_next[rel[PG_W-1:0]] = list_head[cpu];
				next_live[rel[PG_W-1:0]] = head_live[cpu];
				list_head[cpu] = rel[PG_W-1:0];
				head_live[cpu] = 1'b1;
			end
			return g;
		end
		if (!head_live[cpu]) begin
			i = (int'(cpu) + n - 1) % n;
			while (i != int'(cpu) && !head_live[i])
				i = (i + n - 1) % n;
			if (i != int'(cpu)) begin
				first = list_head[i];
				last = first;
				cnt = 0;
				while (head_live[i] && cnt < STEAL_BATCH) begin
					last = list_head[i];
					head_live[i] = next_live[last];
					list_head[i] = page_next[last];
					cnt++;
				end
				next_live[last] = 1'b0;
				page_next[last] = '0;
				list_head[cpu] = first;
				head_live[cpu] = 1'b1;
			end
		end
		if (!head_live[cpu]) begin
			g.st = ST_OOM;
			return g;
		end
		pg = list_head[cpu];
		head_live[cpu] = next_live[pg];
		list_head[cpu] = page_next[pg];
		wide = (64'(base) + 64'(pg)) * PAGE_BYTES;
		g.addr = wide[ADDR_W-1:0];
		return g;
	endfunction

	task automatic issue(cmd_t cmd, int cpu, logic [ADDR_W-1:0] addr);
		grant_t g;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		cpu_id <= cpu[CPU_W-1:0];
		page_address <= addr;
		do @(posedge clk); while (busy);
		g = apply_page_op(cmd, cpu[CPU_W-1:0], addr);
		grant_q.push_back(g);
		if (cmd == CMD_ALLOC && g.st == ST_OK)
			held_pages.push_back(g.addr);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] val);
		logic [PDATA_W-1:0] mask;
		start <= 1'b0;
		while (grant_q.size() != 0)
			@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_NUM_CPUS: begin
				cfg_cpus = val[NCPU_W-1:0];
				mask = {{(PDATA_W-NCPU_W){1'b0}}, {NCPU_W{1'b1}}};
			end
			REG_REGION_START: begin
				cfg_start = val[ADDR_W-1:0];
				mask = {{(PDATA_W-ADDR_W){1'b0}}, {ADDR_W{1'b1}}};
			end
			default: begin
				cfg_end = val[ADDR_W-1:0];
				mask = {{(PDATA_W-ADDR_W){1'b0}}, {ADDR_W{1'b1}}};
			end
		endcase
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) !== (val & mask)) begin
			mismatches++;
			$display("%0t: register %0d read expected %h actual %h", $time, idx, val & mask,
				prdata & mask);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin : check_grants
		grant_t e;
		if (arst_n && done) begin
			if (grant_q.size() == 0) begin
				mismatches++;
				$display("%0t: result beat expected none, actual granted_address %h status %0d",
					$time, granted_address, status);
			end else begin
				e = grant_q.pop_front();
				if (granted_address !== e.addr) begin
					mismatches++;
					$display("%0t: granted_address expected %h actual %h", $time, e.addr,
						granted_address);
				end
				if (status !== e.st) begin
					mismatches++;
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
				end
			end
		end
	end

	task automatic test_bad_requests();
		issue(CMD_FREE, 1, ADDR_TOP);
		issue(CMD_ALLOC, 0, '0);
		issue(CMD_FREE, 0, 40'h00_8000_0800);
		issue(CMD_FREE, 0, 40'h00_7FFF_F000);
		issue(CMD_FREE, 0, REG_END_RST);
	endtask

	// A double free leaves a loop in the list of CPU 0.
	task automatic test_push_pop();
		issue(CMD_FREE, 0, REG_START_RST);
		issue(CMD_FREE, 0, 40'h00_87FF_F000);
		issue(CMD_FREE, 0, REG_START_RST);
		issue(CMD_ALLOC, 0, ADDR_TOP);
		issue(CMD_ALLOC, 0, '0);
		write_reg(REG_REGION_END, 64'(ADDR_TOP));
		issue(CMD_FREE, 0, 40'h00_8800_0000);
	endtask

	task automatic test_cpu_count();
		write_reg(REG_NUM_CPUS, 64'd0);
		issue(CMD_ALLOC, 1, '0);
		write_reg(REG_NUM_CPUS, 64'd15);
		issue(CMD_ALLOC, 7, '0);
	endtask

	task automatic test_steal();
		write_reg(REG_NUM_CPUS, 64'(NUM_CPUS));
		for (int k = 0; k < STEAL_BATCH + 1; k++)
			issue(CMD_FREE, 3, 40'h00_8001_0000 + ADDR_W'(k * PAGE_BYTES));
		issue(CMD_ALLOC, 4, '0);
		issue(CMD_ALLOC, 0, '0);
	endtask

	// Moving region_start relocates every listed page.
	task automatic test_relocation();
		write_reg(REG_REGION_START, 64'({ADDR_TOP[ADDR_W-1:OFF_W], OFF_W'(0)}));
		issue(CMD_FREE, 6, {ADDR_TOP[ADDR_W-1:OFF_W], OFF_W'(0)});
		issue(CMD_ALLOC, 6, '0);
		write_reg(REG_REGION_START, 64'h800);
		issue(CMD_FREE, 6, '0);
		issue(CMD_ALLOC, 6, '0);
	endtask

	task automatic random_block(int n_ops);
		int                 kind;
		int                 fill;
		int                 r;
		int                 idx;
		logic [ADDR_W-1:0]  rs;
		logic [ADDR_W-1:0]  re;
		logic [ADDR_W-1:0]  a;
		logic [ADDR_W:0]    span;
		logic [FRAME_W-1:0] f0;
		write_reg(REG_NUM_CPUS, ($urandom_range(2) == 0) ? 64'($urandom_range(15)) :
			64'($urandom_range(1, NUM_CPUS)));
		kind = $urandom_range(7);
		rs = ADDR_W'({$urandom, $urandom});
		if (kind != 4)
			rs[OFF_W-1:0] = '0;
		span = {1'b0, rs} + ((ADDR_W + 1)'($urandom_range(16, MAX_PAGES + 2000)) << OFF_W);
		re = span[ADDR_W] ? ADDR_TOP : span[ADDR_W-1:0];
		case (kind)
			3: begin
				rs = '0;
				re = ADDR_TOP;
			end
			5: begin
				rs = REG_START_RST;
				re = REG_END_RST;
			end
			6: begin
				rs = {ADDR_TOP[ADDR_W-1:OFF_W] - FRAME_W'($urandom_range(64)), OFF_W'(0)};
				re = ADDR_TOP;
			end
			7: re = ADDR_W'({$urandom, $urandom});
			default: ;
		endcase
		write_reg(REG_REGION_START, 64'(rs));
		write_reg(REG_REGION_END, 64'(re));
		held_pages.delete();
		f0 = rs[ADDR_W-1:OFF_W] + FRAME_W'(rs[OFF_W-1:0] != '0);
		fill = $urandom_range(4, 24);
		for (int k = 0; k < fill; k++)
			issue(CMD_FREE, pick_cpu(), {f0 + FRAME_W'(k), OFF_W'(0)});
		for (int k = 0; k < n_ops; k++) begin
			r = $urandom_range(99);
			if (r < 8) begin
				a = ($urandom_range(1) == 0) ? ADDR_W'({$urandom, $urandom}) :
					{f0 + FRAME_W'($urandom_range(31)), OFF_W'($urandom_range(1, PAGE_BYTES - 1))};
				issue(cmd_t'($urandom_range(1)), $urandom_range(7), a);
			end else if (r < 50 || (r < 92 && held_pages.size() == 0)) begin
				issue(CMD_ALLOC, pick_cpu(), ADDR_W'({$urandom, $urandom}));
			end else if (r < 92) begin
				idx = $urandom_range(held_pages.size() - 1);
				a = held_pages[idx];
				held_pages.delete(idx);
				issue(CMD_FREE, pick_cpu(), a);
			end else begin
				issue(CMD_FREE, pick_cpu(), {f0 + FRAME_W'($urandom_range(31)), OFF_W'(0)});
			end
		end
	endtask

	task automatic test_random(int pct);
		idle_pct = pct;
		repeat (4) random_block(45);
	endtask

	initial begin
		idle_pct = 17;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bad_requests();
		test_push_pop();
		test_cpu_count();
		test_steal();
		test_relocation();
		test_random(17);
		test_random(67);
		test_random(0);
		start <= 1'b0;
		while (grant_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("tb_per_cpu_page_free_list_allocator passed");
		else
			$display("tb_per_cpu_page_free_list_allocator failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_per_cpu_page_free_list_allocator failed");
		$finish;
	end

endmodule
